[rtl/core/assert_macros.svh]
// Assertion macros shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that a property holds on every rising clock edge outside reset.
`define DRS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Check that a condition never holds outside reset.
`define DRS_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define DRS_ASSERT(lbl, clk, rst_n, prop)
`define DRS_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[rtl/core/drs_pkg.sv]
// Types, constants and codes of the disk request scheduler.
`timescale 1ns / 1ps
package drs_pkg;

    localparam int DEF_TABLE_DEPTH = 32;
    localparam int DISK_BLOCKS     = 360;
    localparam int BLOCKS_PER_CYL  = 9;
    localparam int MAX_REQ_ID      = 32767;
    localparam int LIMIT_W         = 10;
    localparam int REM_W           = 4;
    localparam int BLK_W           = 9;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;

    localparam logic [2:0] KIND_IDLE     = 3'd0;
    localparam logic [2:0] KIND_SERVED   = 3'd1;
    localparam logic [2:0] KIND_REJECTED = 3'd2;
    localparam logic [2:0] KIND_ACCEPTED = 3'd3;
    localparam logic [2:0] KIND_FULL     = 3'd4;
    localparam logic [2:0] KIND_IGNORED  = 3'd5;

    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_SERVE  = 1'b1;

    typedef struct packed {
        logic        command;
        logic [2:0]  op_code;
        logic [15:0] request_id;
        logic [8:0]  blk_num;
        logic [13:0] xfer_size;
        logic [31:0] data_address;
        logic [5:0]  head_cylinder;
    } t_request;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] out_request_id;
        logic [2:0]  out_op_code;
        logic [8:0]  out_block;
        logic [13:0] out_size;
        logic [31:0] out_address;
        logic [3:0]  error_mask;
        logic [5:0]  cylinder;
        logic        track;
        logic [3:0]  sector;
    } t_result;

    // Classified command as queued between front and back
    typedef struct packed {
        logic     is_serve;
        logic     op_none;
        t_request req;
    } t_cmd;

    // One stored table entry
    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] id;
        logic [8:0]  block;
        logic [13:0] size;
        logic [31:0] addr;
    } t_entry;

endpackage

[rtl/core/drs_front.sv]
// Front end: accept requests, classify them and queue them for the back end.
`timescale 1ns / 1ps
module drs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  drs_pkg::t_request i_req,
    output logic            o_cmd_valid,
    input  logic            i_cmd_take,
    output drs_pkg::t_cmd   o_cmd
);

    drs_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          push;
    logic          pop;
    drs_pkg::t_cmd cls;

    assign o_stall     = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push        = i_valid && !o_stall;
    assign pop         = o_cmd_valid && i_cmd_take;

    // Classify the incoming transfer
    always_comb begin
        cls.is_serve = (i_req.command == drs_pkg::CMD_SERVE);
        cls.op_none  = (i_req.op_code == drs_pkg::OP_NONE);
        cls.req      = i_req;
    end

    // Store queued payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

[rtl/core/drs_back.sv]
// Back end: request table, elevator pick, compaction and block translation.
`timescale 1ns / 1ps
module drs_back #(
    parameter int TABLE_DEPTH = drs_pkg::DEF_TABLE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    output logic                            o_cmd_take,
    input  drs_pkg::t_cmd                   i_cmd,
    output logic                            o_valid,
    input  logic                            i_stall,
    output drs_pkg::t_result                o_res,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] o_count
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = drs_pkg::LIMIT_W;
    localparam int RW = drs_pkg::REM_W;
    localparam int BW = drs_pkg::BLK_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [RW:0]   BPC_C   = (RW+1)'(drs_pkg::BLOCKS_PER_CYL);
    localparam logic [BW-1:0] BLKS_C  = BW'(drs_pkg::DISK_BLOCKS);
    // Reciprocal scale, exact for 9-bit dividends and divisors up to 16
    localparam int RECIP_S = 18;
    localparam logic [RECIP_S:0] RECIP_M = (RECIP_S+1)'(
        (2**RECIP_S + drs_pkg::BLOCKS_PER_CYL - 1) / drs_pkg::BLOCKS_PER_CYL);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_PICK  = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;
    localparam logic [2:0] ST_REM   = 3'd6;

    drs_pkg::t_entry r_mem [TABLE_DEPTH];
    drs_pkg::t_entry r_rdata;

    logic [2:0]      r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_chk, n_chk;
    logic [IW-1:0]   r_chk_idx, n_chk_idx;
    logic [LW-1:0]   r_limit, n_limit;
    logic            r_found, n_found;
    logic [IW-1:0]   r_pick_idx, n_pick_idx;
    logic [IW-1:0]   r_any_idx, n_any_idx;
    drs_pkg::t_entry r_pick, n_pick;
    drs_pkg::t_entry r_any, n_any;
    drs_pkg::t_entry r_sel, n_sel;
    logic [BW-1:0]   r_num, n_num;
    logic [RW-1:0]   r_rem, n_rem;
    logic            r_out_valid, n_out_valid;
    drs_pkg::t_result r_out, n_out;

    logic            we;
    logic [IW-1:0]   waddr;
    drs_pkg::t_entry wdata;
    logic [IW-1:0]   raddr;
    logic [BW+RECIP_S-1:0] prod_m;
    logic [BW-1:0]   prod_q;
    logic [BW-1:0]   blk_m1;
    logic [3:0]      mask;
    logic [RW:0]     twice_r;

    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_count = r_count;
    assign o_cmd_take = i_cmd_valid && (r_state == ST_IDLE) && !r_out_valid;

    // Quotient by reciprocal multiply, remainder by multiply back and subtract
    assign prod_m = (BW+RECIP_S)'(r_num) * (BW+RECIP_S)'(RECIP_M);
    assign prod_q = r_num * BW'(BPC_C);
    assign blk_m1 = r_sel.block - 1'b1;

    // Validate the selected entry
    always_comb begin
        mask    = 4'd0;
        mask[0] = (r_sel.op > drs_pkg::OP_WRITE);
        mask[1] = (r_sel.id == 16'd0) || (r_sel.id > 16'(drs_pkg::MAX_REQ_ID));
        mask[2] = (r_sel.block == '0) || (r_sel.block > BLKS_C);
        mask[3] = !((r_sel.size == 14'd4) || (r_sel.size == 14'd16) ||
                    (r_sel.size == 14'd256) || (r_sel.size == 14'd1024));
        twice_r = {r_rem, 1'b0};
    end

    // Sequence the table work
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_chk       = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_limit     = r_limit;
        n_found     = r_found;
        n_pick_idx  = r_pick_idx;
        n_any_idx   = r_any_idx;
        n_pick      = r_pick;
        n_any       = r_any;
        n_sel       = r_sel;
        n_num       = r_num;
        n_rem       = r_rem;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        we          = 1'b0;
        waddr       = r_count[IW-1:0];
        wdata       = '0;
        raddr       = r_idx[IW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd_take) begin
                    n_out = '0;
                    if (!i_cmd.is_serve) begin
                        n_out_valid = 1'b1;
                        if (i_cmd.op_none) begin
                            n_out.kind = drs_pkg::KIND_IGNORED;
                        end else if (r_count >= DEPTH_C) begin
                            n_out.kind = drs_pkg::KIND_FULL;
                        end else begin
                            we          = 1'b1;
                            wdata.op    = i_cmd.req.op_code;
                            wdata.id    = i_cmd.req.request_id;
                            wdata.block = i_cmd.req.blk_num;
                            wdata.size  = i_cmd.req.xfer_size;
                            wdata.addr  = i_cmd.req.data_address;
                            n_count     = r_count + 1'b1;
                            n_out.kind  = drs_pkg::KIND_ACCEPTED;
                        end
                    end else if (r_count == '0) begin
                        n_out_valid = 1'b1;
                        n_out.kind  = drs_pkg::KIND_IDLE;
                    end else begin
                        n_limit = LW'(i_cmd.req.head_cylinder) *
                                  LW'(drs_pkg::BLOCKS_PER_CYL);
                        n_found = 1'b0;
                        n_idx   = '0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // Issue the next read while checking the previous one
                if (r_idx < r_count) begin
                    n_chk     = 1'b1;
                    n_chk_idx = r_idx[IW-1:0];
                    n_idx     = r_idx + 1'b1;
                end
                if (r_chk) begin
                    if ((r_chk_idx == '0) || (r_rdata.block < r_any.block)) begin
                        n_any     = r_rdata;
                        n_any_idx = r_chk_idx;
                    end
                    if (({1'b0, r_rdata.block} > r_limit) &&
                        (!r_found || (r_rdata.block < r_pick.block))) begin
                        n_pick     = r_rdata;
                        n_pick_idx = r_chk_idx;
                        n_found    = 1'b1;
                    end
                end else if (r_idx == r_count) begin
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                n_sel   = r_found ? r_pick : r_any;
                n_idx   = CW'(r_found ? r_pick_idx : r_any_idx) + 1'b1;
                n_state = ST_SHIFT;
            end
            ST_SHIFT: begin
                // Close up the table behind the removed entry
                if (r_idx < r_count) begin
                    n_chk     = 1'b1;
                    n_chk_idx = IW'(r_idx - 1'b1);
                    n_idx     = r_idx + 1'b1;
                end
                if (r_chk) begin
                    we    = 1'b1;
                    waddr = r_chk_idx;
                    wdata = r_rdata;
                end else if (r_idx >= r_count) begin
                    n_count = r_count - 1'b1;
                    n_num   = r_sel.block - 1'b1;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_num   = prod_m[RECIP_S +: BW];
                n_state = ST_REM;
            end
            ST_REM: begin
                n_rem   = RW'(blk_m1 - prod_q);
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_out                = '0;
                n_out.kind           = (mask != 4'd0) ? drs_pkg::KIND_REJECTED
                                                      : drs_pkg::KIND_SERVED;
                n_out.out_request_id = r_sel.id;
                n_out.out_op_code    = r_sel.op;
                n_out.out_block      = r_sel.block;
                n_out.out_size       = r_sel.size;
                n_out.out_address    = r_sel.addr;
                n_out.error_mask     = mask;
                if (!mask[2]) begin
                    n_out.cylinder = r_num[5:0];
                    n_out.track    = (twice_r >= BPC_C);
                    n_out.sector   = (twice_r >= BPC_C) ? 4'(twice_r - BPC_C)
                                                        : 4'(twice_r);
                end
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Table memory with registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_chk       <= n_chk;
            r_out_valid <= n_out_valid;
        end
    end

    // Working payload registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_chk_idx  <= n_chk_idx;
        r_limit    <= n_limit;
        r_found    <= n_found;
        r_pick_idx <= n_pick_idx;
        r_any_idx  <= n_any_idx;
        r_pick     <= n_pick;
        r_any      <= n_any;
        r_sel      <= n_sel;
        r_num      <= n_num;
        r_rem      <= n_rem;
        r_out      <= n_out;
    end

endmodule

[rtl/core/disk_request_scheduler_core.sv]
// Top level of the disk request scheduler: front queue and back engine.
`timescale 1ns / 1ps
// A submit passes from transfer in through the front queue into the result
// register; a serve reads the request table through its single read port
// (one entry per cycle for the pick scan and again for closing up the
// table) and then uses a reciprocal multiply and a remainder step that
// yield cylinder, track and sector. A two-entry queue takes new transfers
// while the back end works, and the result register holds a finished
// result while the sink stalls.
`include "assert_macros.svh"
module disk_request_scheduler_core #(
    parameter int TABLE_DEPTH = drs_pkg::DEF_TABLE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  drs_pkg::t_request i_req,
    output logic             o_valid,
    input  logic             i_stall,
    output drs_pkg::t_result o_res
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic                cmd_valid;
    logic                cmd_take;
    drs_pkg::t_cmd       cmd;
    logic [CW-1:0]       count;
    logic                res_ok;
    logic                res_rej;

    drs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req      (i_req),
        .o_cmd_valid(cmd_valid),
        .i_cmd_take (cmd_take),
        .o_cmd      (cmd)
    );

    drs_back #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .o_cmd_take (cmd_take),
        .i_cmd      (cmd),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res      (o_res),
        .o_count    (count)
    );

    // Classify the outgoing result for the checks
    assign res_ok  = o_valid && (o_res.kind == drs_pkg::KIND_SERVED);
    assign res_rej = o_valid && (o_res.kind == drs_pkg::KIND_REJECTED);

    `DRS_NEVER(a_count_bound, i_clk, i_rst_n, count > DEPTH_C)
    `DRS_ASSERT(a_ok_clean, i_clk, i_rst_n, res_ok |-> (o_res.error_mask == 4'd0))
    `DRS_ASSERT(a_rej_mask, i_clk, i_rst_n, res_rej |-> (o_res.error_mask != 4'd0))
    `DRS_ASSERT(a_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_res)))

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the disk request scheduler core.
`timescale 1ns / 1ps
module tb_top;

    localparam int DEPTH    = drs_pkg::DEF_TABLE_DEPTH;
    localparam int N_RANDOM = 1866;
    localparam int REQ_W    = $bits(drs_pkg::t_request);

    localparam logic       SUB  = drs_pkg::CMD_SUBMIT;
    localparam logic       SRV  = drs_pkg::CMD_SERVE;
    localparam logic [2:0] OP_N = drs_pkg::OP_NONE;
    localparam logic [2:0] OP_R = drs_pkg::OP_READ;
    localparam logic [2:0] OP_W = drs_pkg::OP_WRITE;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    drs_pkg::t_request i_req;
    logic              o_valid;
    logic              i_stall;
    drs_pkg::t_result  o_res;

    disk_request_scheduler_core #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req(i_req), .o_valid(o_valid), .i_stall(i_stall), .o_res(o_res)
    );

    // Predictor copy of the request table, packed in arrival order
    drs_pkg::t_entry  pend_tbl[$];
    drs_pkg::t_result result_q[$];
    int     n_errors;
    int     n_results;
    int     n_served;
    int     n_full;
    int     send_idle_pct;
    int     recv_idle_pct;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic bit size_legal(logic [13:0] s);
        return s == 14'd4 || s == 14'd16 || s == 14'd256 || s == 14'd1024;
    endfunction

    // Compute the result of one command and update the table copy
    function automatic drs_pkg::t_result schedule_step(drs_pkg::t_request rq);
        drs_pkg::t_result r;
        drs_pkg::t_entry  e;
        int      lim;
        int      pick;
        int      best_any;
        int      rem;
        int      sec;
        bit      found;
        r = '0;
        if (rq.command == drs_pkg::CMD_SUBMIT) begin
            if (rq.op_code == drs_pkg::OP_NONE) begin
                r.kind = drs_pkg::KIND_IGNORED;
            end else if (pend_tbl.size() >= DEPTH) begin
                r.kind = drs_pkg::KIND_FULL;
            end else begin
                e.op = rq.op_code;
                e.id = rq.request_id;
                e.block = rq.blk_num;
                e.size = rq.xfer_size;
                e.addr = rq.data_address;
                pend_tbl.push_back(e);
                r.kind = drs_pkg::KIND_ACCEPTED;
            end
            return r;
        end
        if (pend_tbl.size() == 0) begin
            r.kind = drs_pkg::KIND_IDLE;
            return r;
        end
        lim = int'(rq.head_cylinder) * drs_pkg::BLOCKS_PER_CYL;
        pick = 0;
        best_any = 0;
        found = 1'b0;
        for (int i = 0; i < pend_tbl.size(); i++) begin
            if (pend_tbl[i].block < pend_tbl[best_any].block) best_any = i;
            if (int'(pend_tbl[i].block) > lim &&
                (!found || pend_tbl[i].block < pend_tbl[pick].block)) begin
                pick = i;
                found = 1'b1;
            end
        end
        if (!found) pick = best_any;
        e = pend_tbl[pick];
        pend_tbl.delete(pick);
        if (e.op > drs_pkg::OP_WRITE) r.error_mask[0] = 1'b1;
        if (e.id < 16'd1 || e.id > drs_pkg::MAX_REQ_ID) r.error_mask[1] = 1'b1;
        if (e.block < 9'd1 || e.block > drs_pkg::DISK_BLOCKS) r.error_mask[2] = 1'b1;
        if (!size_legal(e.size)) r.error_mask[3] = 1'b1;
        r.kind = (r.error_mask != 4'd0) ? drs_pkg::KIND_REJECTED : drs_pkg::KIND_SERVED;
        r.out_request_id = e.id;
        r.out_op_code = e.op;
        r.out_block = e.block;
        r.out_size = e.size;
        r.out_address = e.addr;
        if (!r.error_mask[2]) begin
            rem = (int'(e.block) - 1) % drs_pkg::BLOCKS_PER_CYL;
            sec = 2 * rem;
            if (sec >= drs_pkg::BLOCKS_PER_CYL) sec -= drs_pkg::BLOCKS_PER_CYL;
            r.cylinder = 6'((int'(e.block) - 1) / drs_pkg::BLOCKS_PER_CYL);
            r.track = (2 * rem < drs_pkg::BLOCKS_PER_CYL) ? 1'b0 : 1'b1;
            r.sector = 4'(sec);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        n_errors++;
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    // Sink: random stall, compare each transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b1;
        end else begin
            if (o_valid && !i_stall) begin
                n_results++;
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected result", 32'(o_res.kind), 32'd0);
                end else begin
                    drs_pkg::t_result w;
                    w = result_q.pop_front();
                    if (o_res.kind == drs_pkg::KIND_SERVED ||
                        o_res.kind == drs_pkg::KIND_REJECTED) n_served++;
                    if (o_res.kind == drs_pkg::KIND_FULL) n_full++;
                    if (o_res.kind != w.kind)
                        report_mismatch("kind", 32'(o_res.kind), 32'(w.kind));
                    if (o_res.out_request_id != w.out_request_id)
                        report_mismatch("request_id", 32'(o_res.out_request_id),
                                        32'(w.out_request_id));
                    if (o_res.out_op_code != w.out_op_code)
                        report_mismatch("op_code", 32'(o_res.out_op_code),
                                        32'(w.out_op_code));
                    if (o_res.out_block != w.out_block)
                        report_mismatch("block", 32'(o_res.out_block), 32'(w.out_block));
                    if (o_res.out_size != w.out_size)
                        report_mismatch("size", 32'(o_res.out_size), 32'(w.out_size));
                    if (o_res.out_address != w.out_address)
                        report_mismatch("address", o_res.out_address, w.out_address);
                    if (o_res.error_mask != w.error_mask)
                        report_mismatch("error_mask", 32'(o_res.error_mask),
                                        32'(w.error_mask));
                    if (o_res.cylinder != w.cylinder)
                        report_mismatch("cylinder", 32'(o_res.cylinder), 32'(w.cylinder));
                    if (o_res.track != w.track)
                        report_mismatch("track", 32'(o_res.track), 32'(w.track));
                    if (o_res.sector != w.sector)
                        report_mismatch("sector", 32'(o_res.sector), 32'(w.sector));
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Hold one command until transferred, with random idle cycles ahead;
    // valid stays high into the next call so commands can follow back to back
    task automatic send_cmd(drs_pkg::t_request rq);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= rq;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        result_q.push_back(schedule_step(rq));
    endtask

    function automatic drs_pkg::t_request rand_bits();
        return drs_pkg::t_request'(REQ_W'({$urandom, $urandom, $urandom}));
    endfunction

    // Submit a well-formed request with random content
    function automatic drs_pkg::t_request good_submit();
        drs_pkg::t_request rq;
        logic [13:0] sizes [4] = '{14'd4, 14'd16, 14'd256, 14'd1024};
        rq = rand_bits();
        rq.command = SUB;
        rq.op_code = 3'($urandom_range(1, 2));
        rq.request_id = 16'($urandom_range(1, drs_pkg::MAX_REQ_ID));
        rq.blk_num = 9'($urandom_range(1, drs_pkg::DISK_BLOCKS));
        rq.xfer_size = sizes[2'($urandom_range(3))];
        return rq;
    endfunction

    function automatic drs_pkg::t_request rand_cmd();
        drs_pkg::t_request rq;
        int sel;
        sel = $urandom_range(99);
        if (sel < 45) begin
            rq = good_submit();
            if ($urandom_range(9) == 0) rq.op_code = 3'($urandom_range(3, 7));
            if ($urandom_range(9) == 0) rq.request_id = 16'($urandom_range(32768, 65535));
            if ($urandom_range(9) == 0) rq.blk_num = 9'($urandom_range(361, 511));
            if ($urandom_range(9) == 0) rq.xfer_size = 14'($urandom);
        end else if (sel < 55) begin
            rq = rand_bits();
            rq.command = SUB;
        end else begin
            rq = rand_bits();
            rq.command = SRV;
        end
        return rq;
    endfunction

    // Drop valid and wait until every expected result has come
    task automatic drain();
        i_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // Directed table: command, op, id, block, size, address, head, expected kind
    typedef struct {
        drs_pkg::t_request rq;
        bit         has_kind;
        logic [2:0] kind;
    } t_row;

    t_row dir_rows[$];

    function automatic drs_pkg::t_request mk(logic c, logic [2:0] op, logic [15:0] id,
                                             logic [8:0] blk, logic [13:0] sz,
                                             logic [31:0] a, logic [5:0] hd);
        drs_pkg::t_request rq;
        rq.command = c;
        rq.op_code = op;
        rq.request_id = id;
        rq.blk_num = blk;
        rq.xfer_size = sz;
        rq.data_address = a;
        rq.head_cylinder = hd;
        return rq;
    endfunction

    function automatic drs_pkg::t_request srv(logic [5:0] hd);
        return mk(SRV, OP_N, 16'd0, 9'd0, 14'd0, 32'h0, hd);
    endfunction

    function automatic void add_row(drs_pkg::t_request rq, bit has, logic [2:0] k);
        t_row row;
        row.rq = rq;
        row.has_kind = has;
        row.kind = k;
        dir_rows.push_back(row);
    endfunction

    initial begin
        drs_pkg::t_request rq;
        n_errors = 0;
        n_results = 0;
        n_served = 0;
        n_full = 0;
        send_idle_pct = 29;
        recv_idle_pct = 63;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty serve, ignored submit, extremes, bad fields, pick order
        add_row(srv(6'd63), 1'b1, drs_pkg::KIND_IDLE);
        add_row(mk(SUB, OP_N, 16'd5, 9'd5, 14'd4, 32'h1, 6'd0), 1'b1,
                drs_pkg::KIND_IGNORED);
        add_row(mk(SUB, OP_R, 16'd1, 9'd1, 14'd4, 32'h0, 6'd0), 1'b1,
                drs_pkg::KIND_ACCEPTED);
        add_row(mk(SUB, OP_W, 16'd32767, 9'd360, 14'd1024, '1, 6'd0), 1'b1,
                drs_pkg::KIND_ACCEPTED);
        add_row(mk(SUB, 3'd7, 16'd0, 9'd0, 14'd0, 32'h1234, 6'd0), 1'b1,
                drs_pkg::KIND_ACCEPTED);
        add_row(mk(SUB, 3'd3, 16'd65535, 9'd511, 14'd16383, 32'h5a5a, 6'd0), 1'b1,
                drs_pkg::KIND_ACCEPTED);
        add_row(mk(SUB, OP_R, 16'd32768, 9'd100, 14'd16, 32'h77, 6'd0), 1'b1,
                drs_pkg::KIND_ACCEPTED);
        add_row(mk(SUB, OP_W, 16'd9, 9'd100, 14'd256, 32'h88, 6'd0), 1'b1,
                drs_pkg::KIND_ACCEPTED);
        add_row(mk(SUB, OP_R, 16'd10, 9'd10, 14'd5, 32'h99, 6'd0), 1'b1,
                drs_pkg::KIND_ACCEPTED);
        add_row(srv(6'd10), 1'b0, drs_pkg::KIND_IDLE);
        add_row(srv(6'd10), 1'b0, drs_pkg::KIND_IDLE);
        add_row(srv(6'd63), 1'b0, drs_pkg::KIND_IDLE);
        add_row(srv(6'd0), 1'b0, drs_pkg::KIND_IDLE);
        add_row(srv(6'd39), 1'b0, drs_pkg::KIND_IDLE);
        add_row(srv(6'd0), 1'b0, drs_pkg::KIND_IDLE);
        add_row(srv(6'd0), 1'b0, drs_pkg::KIND_IDLE);
        add_row(srv(6'd0), 1'b1, drs_pkg::KIND_IDLE);
        foreach (dir_rows[i]) begin
            send_cmd(dir_rows[i].rq);
            if (dir_rows[i].has_kind) result_q[$].kind = dir_rows[i].kind;
        end
        // Fill the table past full, then empty it
        for (int i = 0; i < DEPTH + 2; i++) send_cmd(good_submit());
        for (int i = 0; i < DEPTH + 1; i++) begin
            rq = rand_bits();
            rq.command = SRV;
            send_cmd(rq);
        end
        drain();

        // Random phases with swapped and then no idling
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 63 : 0;
            recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 29 : 0;
            for (int n = 0; n < N_RANDOM / 3; n++) begin
                send_cmd(rand_cmd());
                // Hold off once per phase until the block has caught up
                if (n == N_RANDOM / 6) begin
                    i_valid <= 1'b0;
                    while (result_q.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        $display("covered %0d results, %0d serves, %0d full-table rejects",
                 n_results, n_served, n_full);
        if (n_errors == 0 && result_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
